// ----- hdl/gbp_pkg.sv -----
// shared sizes, types and codes for the gshare / bimodal predictor with btb
package gbp_pkg;

   localparam int CNT_ENTRIES = 1024;
   localparam int CNT_IDX_W   = $clog2(CNT_ENTRIES);
   localparam int BTB_ENTRIES = 256;
   localparam int BTB_WAYS    = 4;
   localparam int BTB_SETS    = BTB_ENTRIES / BTB_WAYS;
   localparam int SET_W       = $clog2(BTB_SETS);
   localparam int WAY_W       = $clog2(BTB_WAYS);
   localparam int RANK_W      = WAY_W;
   localparam int OLD_W       = WAY_W + 1;
   localparam int ADDR_W      = 32;
   localparam int TAG_W       = ADDR_W - 2 - SET_W;
   localparam int HIST_W      = 32;
   localparam int HLEN_W      = 6;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 6;

   typedef logic [ADDR_W-1:0]              addr_type;
   typedef logic [TAG_W-1:0]               tag_type;
   typedef logic [RANK_W-1:0]              rank_type;
   typedef logic [1:0]                     ctr_type;
   typedef logic [1:0]                     outc_type;
   typedef tag_type  [BTB_WAYS-1:0]        tag_row_type;
   typedef addr_type [BTB_WAYS-1:0]        tgt_row_type;
   typedef rank_type [BTB_WAYS-1:0]        rank_row_type;

   // item actions
   localparam logic ACT_PREDICT = 1'b0;
   localparam logic ACT_RESOLVE = 1'b1;

   // result classification
   localparam outc_type OUTC_PREDICT  = 2'd0;
   localparam outc_type OUTC_CORRECT  = 2'd1;
   localparam outc_type OUTC_DIR_MISS = 2'd2;
   localparam outc_type OUTC_TGT_MISS = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIST_LEN = 1'b1;

   localparam logic MODE_BIMODAL = 1'b0;
   localparam logic MODE_GSHARE  = 1'b1;

   localparam ctr_type  CTR_MIN     = 2'd0;
   localparam ctr_type  CTR_WEAK_NT = 2'd1;
   localparam ctr_type  CTR_MAX     = 2'd3;
   localparam addr_type PC_STEP     = 32'd4;
   localparam logic [HLEN_W-1:0] HLEN_RESET = 6'd10;

endpackage

// ----- hdl/gshare_bimodal_predictor_with_btb.sv -----
// gshare / bimodal direction predictor with a set-associative branch target buffer
//
// req channel: one item per predict or resolve; accepted when req_valid is high and
// req_stall is low. rsp channel: exactly one item per request, in order, taken when
// rsp_valid is high and rsp_stall is low. csr channel: register writes (index 0 mode,
// index 1 history length), always ready; writes must be issued only while the block
// is idle, which is not enforced. an accepted item passes the compute stage register,
// then the output register. throughput: one item per cycle unless rsp stalls or the
// sweep runs, set by the single read-modify-write pass over the counter and btb row
// rams, with a one-deep write bypass covering back to back items on the same entry.
// reset: history clears, btb valid bits clear, registers take their reset values, and
// a clearing sweep writes weakly-not-taken into all 1024 counters, one per cycle;
// req_stall stays high until the sweep ends.
// stall: a stalled rsp holds the output register; the item in the compute stage waits
// behind it and req_stall rises in the same cycle, so no item is dropped.
module gshare_bimodal_predictor_with_btb
   import gbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [31:0]           req_pc,
   input  logic                  req_predicted_taken,
   input  logic [31:0]           req_predicted_target,
   input  logic                  req_actual_taken,
   input  logic [31:0]           req_actual_target,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_pred_taken,
   output logic                  rsp_btb_hit,
   output logic [31:0]           rsp_pred_target,
   output logic [1:0]            rsp_outcome,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration and history
   logic              mode_ff;
   logic [HLEN_W-1:0] hist_len_ff;
   logic [HIST_W-1:0] hist_ff, hist_in, hist_mask;

   // counter clearing sweep
   logic                 clear_ff;
   logic [CNT_IDX_W-1:0] clr_ff;

   // handshake
   logic req_accept, s1_go, s1_fire;

   // compute stage
   logic                 s1_valid_ff;
   logic                 s1_action_ff;
   addr_type             s1_pc_ff;
   logic                 s1_ptaken_ff;
   addr_type             s1_ptgt_ff;
   logic                 s1_ataken_ff;
   addr_type             s1_atgt_ff;
   logic [CNT_IDX_W-1:0] s1_cidx_ff;
   logic [CNT_IDX_W-1:0] req_cidx;

   // memories and read registers
   ctr_type      ctr_mem  [CNT_ENTRIES];
   tag_row_type  tag_mem  [BTB_SETS];
   tgt_row_type  tgt_mem  [BTB_SETS];
   rank_row_type rank_mem [BTB_SETS];
   ctr_type      ctr_rd_ff;
   tag_row_type  tag_rd_ff;
   tgt_row_type  tgt_rd_ff;
   rank_row_type rank_rd_ff;
   logic [BTB_WAYS-1:0] btb_vld_ff [BTB_SETS];

   // write bypass
   logic                 byp_ctr_vld_ff;
   logic [CNT_IDX_W-1:0] byp_cidx_ff;
   ctr_type              byp_ctr_ff;
   logic                 byp_btb_vld_ff;
   logic [SET_W-1:0]     byp_set_ff;
   tag_row_type          byp_tag_ff;
   tgt_row_type          byp_tgt_ff;
   rank_row_type         byp_rank_ff;

   // compute signals
   logic [SET_W-1:0]     s1_set;
   tag_type              s1_tag;
   ctr_type              ctr_cur, ctr_new;
   tag_row_type          tag_row, tag_new;
   tgt_row_type          tgt_row, tgt_new;
   rank_row_type         rank_row, rank_new;
   logic [BTB_WAYS-1:0]  vld_row, hit_vec;
   logic                 hit, inv_found;
   logic [WAY_W-1:0]     hit_way, inv_way, old_way, sel_way;
   logic [OLD_W-1:0]     old_rank;
   addr_type             look_target;
   outc_type             res_outc;
   logic                 is_res, ctr_we, btb_we;
   logic [CNT_IDX_W-1:0] ctr_waddr;
   ctr_type              ctr_wdata;

   // output register
   logic     rsp_valid_ff, rsp_pred_taken_ff, rsp_btb_hit_ff;
   addr_type rsp_target_ff;
   outc_type rsp_outcome_ff;

   assign csr_ready  = 1'b1;
   assign s1_go      = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && s1_go;
   assign req_stall  = clear_ff || (s1_valid_ff && !s1_go);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (hist_len_ff >= HLEN_W'(HIST_W)) begin
         hist_mask = '1;
      end else begin
         hist_mask = (HIST_W'(1) << hist_len_ff) - HIST_W'(1);
      end
   end

   // index uses history as it stands before this item's own update
   always_comb begin
      if (mode_ff == MODE_BIMODAL) begin
         req_cidx = req_pc[CNT_IDX_W+1:2];
      end else begin
         req_cidx = req_pc[CNT_IDX_W+1:2] ^ hist_mask[CNT_IDX_W-1:0]
                    & hist_ff[CNT_IDX_W-1:0];
      end
   end

   always_comb begin
      hist_in = hist_ff;
      if (req_accept && req_action == ACT_RESOLVE) begin
         hist_in = {hist_ff[HIST_W-2:0], req_actual_taken} & hist_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_GSHARE;
         hist_len_ff <= HLEN_RESET;
         hist_ff     <= '0;
      end else begin
         hist_ff <= hist_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:     mode_ff     <= csr_wdata[0];
               CSR_HIST_LEN: hist_len_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clr_ff   <= '0;
      end else if (clear_ff) begin
         clr_ff <= clr_ff + CNT_IDX_W'(1);
         if (clr_ff == CNT_IDX_W'(CNT_ENTRIES - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // compute stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= req_action;
         s1_pc_ff     <= req_pc;
         s1_ptaken_ff <= req_predicted_taken;
         s1_ptgt_ff   <= req_predicted_target;
         s1_ataken_ff <= req_actual_taken;
         s1_atgt_ff   <= req_actual_target;
         s1_cidx_ff   <= req_cidx;
      end
   end

   assign s1_set = s1_pc_ff[SET_W+1:2];
   assign s1_tag = s1_pc_ff[ADDR_W-1:SET_W+2];
   assign is_res = s1_action_ff == ACT_RESOLVE;

   // counter ram
   assign ctr_we    = clear_ff || (s1_fire && is_res);
   assign ctr_waddr = clear_ff ? clr_ff : s1_cidx_ff;
   assign ctr_wdata = clear_ff ? CTR_WEAK_NT : ctr_new;

   always_ff @(posedge clock) begin
      if (ctr_we) begin
         ctr_mem[ctr_waddr] <= ctr_wdata;
      end
      if (req_accept) begin
         ctr_rd_ff <= ctr_mem[req_cidx];
      end
   end

   // btb row rams
   assign btb_we = s1_fire && is_res && s1_ataken_ff;

   always_ff @(posedge clock) begin
      if (btb_we) begin
         tag_mem[s1_set]  <= tag_new;
         tgt_mem[s1_set]  <= tgt_new;
         rank_mem[s1_set] <= rank_new;
      end
      if (req_accept) begin
         tag_rd_ff  <= tag_mem[req_pc[SET_W+1:2]];
         tgt_rd_ff  <= tgt_mem[req_pc[SET_W+1:2]];
         rank_rd_ff <= rank_mem[req_pc[SET_W+1:2]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < BTB_SETS; s++) begin
            btb_vld_ff[s] <= '0;
         end
      end else if (btb_we) begin
         btb_vld_ff[s1_set][sel_way] <= 1'b1;
      end
   end

   // last write, for an item whose read raced that write
   always_ff @(posedge clock) begin
      if (reset || clear_ff) begin
         byp_ctr_vld_ff <= 1'b0;
         byp_btb_vld_ff <= 1'b0;
      end else begin
         if (s1_fire && is_res) begin
            byp_ctr_vld_ff <= 1'b1;
         end
         if (btb_we) begin
            byp_btb_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && is_res) begin
         byp_cidx_ff <= s1_cidx_ff;
         byp_ctr_ff  <= ctr_new;
      end
      if (btb_we) begin
         byp_set_ff  <= s1_set;
         byp_tag_ff  <= tag_new;
         byp_tgt_ff  <= tgt_new;
         byp_rank_ff <= rank_new;
      end
   end

   always_comb begin
      ctr_cur = (byp_ctr_vld_ff && byp_cidx_ff == s1_cidx_ff) ? byp_ctr_ff : ctr_rd_ff;
      if (byp_btb_vld_ff && byp_set_ff == s1_set) begin
         tag_row  = byp_tag_ff;
         tgt_row  = byp_tgt_ff;
         rank_row = byp_rank_ff;
      end else begin
         tag_row  = tag_rd_ff;
         tgt_row  = tgt_rd_ff;
         rank_row = rank_rd_ff;
      end
      vld_row = btb_vld_ff[s1_set];
   end

   // way lookup and replacement choice
   always_comb begin
      hit_way   = '0;
      inv_way   = '0;
      inv_found = 1'b0;
      old_way   = '0;
      for (int w = 0; w < BTB_WAYS; w++) begin
         hit_vec[w] = vld_row[w] && tag_row[w] == s1_tag;
      end
      hit = |hit_vec;
      for (int w = BTB_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (!vld_row[w]) begin
            inv_way   = WAY_W'(w);
            inv_found = 1'b1;
         end
      end
      // oldest rank, earliest way on a tie
      for (int w = 1; w < BTB_WAYS; w++) begin
         if (rank_row[w] > rank_row[old_way]) begin
            old_way = WAY_W'(w);
         end
      end
      if (hit) begin
         sel_way = hit_way;
      end else if (inv_found) begin
         sel_way = inv_way;
      end else begin
         sel_way = old_way;
      end
   end

   // new row contents for a taken resolve
   always_comb begin
      // an invalid way counts as older than every valid one
      old_rank = vld_row[sel_way] ? {1'b0, rank_row[sel_way]} : OLD_W'(BTB_WAYS);
      tag_new  = tag_row;
      tgt_new  = tgt_row;
      rank_new = rank_row;
      for (int w = 0; w < BTB_WAYS; w++) begin
         if (WAY_W'(w) == sel_way) begin
            rank_new[w] = '0;
         end else if (vld_row[w] && {1'b0, rank_row[w]} < old_rank) begin
            rank_new[w] = rank_row[w] + RANK_W'(1);
         end
      end
      tag_new[sel_way] = s1_tag;
      tgt_new[sel_way] = s1_atgt_ff;
   end

   always_comb begin
      if (s1_ataken_ff) begin
         ctr_new = (ctr_cur == CTR_MAX) ? ctr_cur : ctr_cur + 2'd1;
      end else begin
         ctr_new = (ctr_cur == CTR_MIN) ? ctr_cur : ctr_cur - 2'd1;
      end
      look_target = hit ? tgt_row[hit_way] : s1_pc_ff + PC_STEP;
      if (s1_ptaken_ff != s1_ataken_ff) begin
         res_outc = OUTC_DIR_MISS;
      end else if (s1_ataken_ff && s1_ptgt_ff != s1_atgt_ff) begin
         res_outc = OUTC_TGT_MISS;
      end else begin
         res_outc = OUTC_CORRECT;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         if (is_res) begin
            rsp_pred_taken_ff <= 1'b0;
            rsp_btb_hit_ff    <= 1'b0;
            rsp_target_ff     <= '0;
            rsp_outcome_ff    <= res_outc;
         end else begin
            rsp_pred_taken_ff <= ctr_cur[1];
            rsp_btb_hit_ff    <= hit;
            rsp_target_ff     <= look_target;
            rsp_outcome_ff    <= OUTC_PREDICT;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pred_taken  = rsp_pred_taken_ff;
   assign rsp_btb_hit     = rsp_btb_hit_ff;
   assign rsp_pred_target = rsp_target_ff;
   assign rsp_outcome     = rsp_outcome_ff;

   a_clear_blocks_items: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (req_stall && !s1_valid_ff))
      else $error("item taken during counter clearing sweep");

   a_tag_unique: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot0(hit_vec))
      else $error("more than one btb way matches the tag");

   a_resolve_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_outcome_ff == OUTC_PREDICT) ||
                       (!rsp_pred_taken_ff && !rsp_btb_hit_ff && rsp_target_ff == '0))
      else $error("resolve item carries prediction fields");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without an item in the compute stage");

endmodule

// ----- verif/gshare_bimodal_predictor_with_btb_test.sv -----
// self-checking testbench for the gshare / bimodal branch predictor with btb
`timescale 1ns / 100ps

module gshare_bimodal_predictor_with_btb_test;
   import gbp_pkg::*;

   localparam ctr_type CTR_TAKEN_MIN  = 2'd2;
   localparam int      WATCHDOG_LIMIT = 5000;
   localparam int      LONG_HOLD_AT   = 1150;
   localparam int      LONG_HOLD_LEN  = 150;

   typedef struct {
      logic     action;
      addr_type pc;
      logic     p_taken;
      addr_type p_target;
      logic     a_taken;
      addr_type a_target;
   } branch_item_type;

   typedef struct {
      logic     taken;
      logic     hit;
      addr_type target;
      outc_type outcome;
   } lookup_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_action = ACT_PREDICT;
   logic [31:0]           req_pc = '0;
   logic                  req_predicted_taken = 1'b0;
   logic [31:0]           req_predicted_target = '0;
   logic                  req_actual_taken = 1'b0;
   logic [31:0]           req_actual_target = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_pred_taken;
   logic                  rsp_btb_hit;
   logic [31:0]           rsp_pred_target;
   logic [1:0]            rsp_outcome;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   gshare_bimodal_predictor_with_btb uut (.*);

   // predictor state
   ctr_type           dir_ctr    [CNT_ENTRIES];
   logic [HIST_W-1:0] ghist;
   logic              way_valid  [BTB_SETS][BTB_WAYS];
   tag_type           way_tag    [BTB_SETS][BTB_WAYS];
   addr_type          way_target [BTB_SETS][BTB_WAYS];
   rank_type          way_rank   [BTB_SETS][BTB_WAYS];
   logic              cfg_mode;
   logic [HLEN_W-1:0] cfg_hlen;

   branch_item_type branch_queue[$];
   lookup_type      expected_lookups[$];
   branch_item_type offered;
   tag_type      tag_tbl [6];
   addr_type     tgt_tbl [6];
   logic [SET_W-1:0] set_tbl [3];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int failures = 0;
   int results_seen = 0;
   int hold_left = 0;
   bit hold_done = 0;
   int quiet_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [HIST_W-1:0] hist_mask();
      if (cfg_hlen >= 6'd32) return '1;
      return (32'd1 << cfg_hlen) - 32'd1;
   endfunction

   function automatic int ctr_slot(addr_type pc);
      logic [HIST_W-1:0] mixed;
      mixed = {2'b00, pc[31:2]};
      if (cfg_mode == MODE_GSHARE) mixed = mixed ^ (ghist & hist_mask());
      return int'(mixed[CNT_IDX_W-1:0]);
   endfunction

   // written way becomes rank 0, younger valid ways age by one
   function automatic void make_recent(int s, int w);
      int old_rank;
      old_rank = way_valid[s][w] ? int'(way_rank[s][w]) : BTB_WAYS;
      for (int i = 0; i < BTB_WAYS; i++)
         if (i != w && way_valid[s][i] && int'(way_rank[s][i]) < old_rank)
            way_rank[s][i] = way_rank[s][i] + 1'b1;
      way_rank[s][w] = '0;
   endfunction

   function automatic void btb_fill(addr_type pc, addr_type tgt);
      int      s;
      int      victim;
      bit      found;
      tag_type t;
      s = int'(pc[2 +: SET_W]);
      t = tag_type'(pc >> (SET_W + 2));
      victim = 0;
      found = 0;
      for (int i = 0; i < BTB_WAYS; i++) begin
         if (way_valid[s][i] && way_tag[s][i] == t) begin
            way_target[s][i] = tgt;
            make_recent(s, i);
            return;
         end
      end
      for (int i = 0; i < BTB_WAYS; i++) begin
         if (!found && !way_valid[s][i]) begin
            victim = i;
            found = 1;
         end
      end
      if (!found)
         for (int i = 1; i < BTB_WAYS; i++)
            if (way_rank[s][i] > way_rank[s][victim]) victim = i;
      make_recent(s, victim);
      way_valid[s][victim] = 1'b1;
      way_tag[s][victim] = t;
      way_target[s][victim] = tgt;
   endfunction

   function automatic lookup_type compute_lookup(branch_item_type b);
      lookup_type r;
      int      slot;
      int      s;
      tag_type t;
      slot = ctr_slot(b.pc);
      r.taken = 1'b0;
      r.hit = 1'b0;
      r.target = '0;
      if (b.action == ACT_PREDICT) begin
         s = int'(b.pc[2 +: SET_W]);
         t = tag_type'(b.pc >> (SET_W + 2));
         r.target = b.pc + PC_STEP;
         for (int i = 0; i < BTB_WAYS; i++) begin
            if (!r.hit && way_valid[s][i] && way_tag[s][i] == t) begin
               r.hit = 1'b1;
               r.target = way_target[s][i];
            end
         end
         r.taken = (dir_ctr[slot] >= CTR_TAKEN_MIN);
         r.outcome = OUTC_PREDICT;
      end else begin
         if (b.p_taken != b.a_taken) r.outcome = OUTC_DIR_MISS;
         else if (b.a_taken && b.p_target != b.a_target) r.outcome = OUTC_TGT_MISS;
         else r.outcome = OUTC_CORRECT;
         if (b.a_taken) begin
            if (dir_ctr[slot] != CTR_MAX) dir_ctr[slot] = dir_ctr[slot] + 1'b1;
            btb_fill(b.pc, b.a_target);
         end else if (dir_ctr[slot] != CTR_MIN) begin
            dir_ctr[slot] = dir_ctr[slot] - 1'b1;
         end
         ghist = ((ghist << 1) | HIST_W'(b.a_taken)) & hist_mask();
      end
      return r;
   endfunction

   // mostly a few crowded sets so resolves train what later predicts read
   function automatic branch_item_type random_branch();
      branch_item_type b;
      int           k;
      k = $urandom_range(0, 5);
      b.action = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) != 0) begin
         b.pc = {tag_tbl[k], set_tbl[$urandom_range(0, 2)], 2'b00};
         if ($urandom_range(0, 7) == 0) b.pc[1:0] = 2'($urandom_range(0, 3));
      end else begin
         b.pc = $urandom;
      end
      b.a_taken = 1'($urandom_range(0, 1));
      b.a_target = ($urandom_range(0, 2) != 0) ? tgt_tbl[k] : addr_type'($urandom);
      b.p_taken = ($urandom_range(0, 3) != 0) ? b.a_taken : !b.a_taken;
      b.p_target = ($urandom_range(0, 2) != 0) ? b.a_target : addr_type'($urandom);
      return b;
   endfunction

   task automatic push_item(logic act, addr_type pc, logic pt, addr_type ptg,
                            logic at, addr_type atg);
      branch_item_type b;
      b.action = act;
      b.pc = pc;
      b.p_taken = pt;
      b.p_target = ptg;
      b.a_taken = at;
      b.a_target = atg;
      branch_queue.push_back(b);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (branch_queue.size() != 0 || req_valid || expected_lookups.size() != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MODE) cfg_mode = data[0];
      else cfg_hlen = data;
      @(negedge clock);
   endtask

   task automatic run_phase(logic mode, logic [HLEN_W-1:0] hlen, int items,
                            int send_pct, int recv_pct);
      wait_drained();
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      write_reg(CSR_MODE, CSR_DATA_W'(mode));
      write_reg(CSR_HIST_LEN, hlen);
      repeat (items) branch_queue.push_back(random_branch());
   endtask

   // stimulus and phase control
   initial begin
      for (int i = 0; i < CNT_ENTRIES; i++) dir_ctr[i] = CTR_WEAK_NT;
      for (int s = 0; s < BTB_SETS; s++)
         for (int w = 0; w < BTB_WAYS; w++) begin
            way_valid[s][w] = 1'b0;
            way_rank[s][w] = '0;
         end
      ghist = '0;
      cfg_mode = MODE_GSHARE;
      cfg_hlen = HLEN_RESET;
      for (int i = 0; i < 6; i++) begin
         tag_tbl[i] = tag_type'($urandom);
         tgt_tbl[i] = $urandom;
      end
      for (int i = 0; i < 3; i++) set_tbl[i] = SET_W'($urandom);

      send_idle_pct = 20;
      recv_stall_pct = 20;
      push_item(ACT_PREDICT, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0);
      // pc + 4 wraps around
      push_item(ACT_PREDICT, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
      push_item(ACT_RESOLVE, 32'h100, 1'b1, 32'h2000, 1'b1, 32'h2000);
      push_item(ACT_RESOLVE, 32'h100, 1'b1, 32'h2004, 1'b1, 32'h2000);
      // not-taken resolve ignores both targets
      push_item(ACT_RESOLVE, 32'h100, 1'b0, 32'h1234, 1'b0, 32'h9876);
      push_item(ACT_RESOLVE, 32'h100, 1'b0, 32'h2000, 1'b1, 32'h2000);
      push_item(ACT_PREDICT, 32'h100, 1'b0, 32'h0, 1'b0, 32'h0);
      // five tags into one set: fifth evicts the oldest way
      for (int k = 1; k <= 5; k++)
         push_item(ACT_RESOLVE, 32'h1_0000 * k + 32'h40, 1'b1, 32'h0, 1'b1, 32'h3000 + k);
      push_item(ACT_RESOLVE, 32'h2_0040, 1'b1, 32'h0, 1'b1, 32'h7777_0000);
      for (int k = 1; k <= 5; k++)
         push_item(ACT_PREDICT, 32'h1_0000 * k + 32'h40, 1'b0, 32'h0, 1'b0, 32'h0);
      repeat (3) push_item(ACT_RESOLVE, 32'h200, 1'b1, 32'h0, 1'b0, 32'h0);
      push_item(ACT_RESOLVE, 32'hffff_ffff, 1'b1, 32'h0, 1'b1, 32'hffff_ffff);
      push_item(ACT_PREDICT, 32'hffff_ffff, 1'b0, 32'h0, 1'b0, 32'h0);
      push_item(ACT_RESOLVE, 32'h0, 1'b0, 32'h0, 1'b1, 32'h0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_phase(MODE_BIMODAL, 6'd32, 500, 34, 85);
      // zero history length: gshare degenerates to bimodal
      run_phase(MODE_GSHARE, 6'd0, 500, 85, 34);
      run_phase(MODE_GSHARE, 6'd32, 400, 0, 0);
      run_phase(MODE_GSHARE, 6'd1, 200, 0, 0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_lookups.push_back(compute_lookup(offered));
         if (!req_valid || !req_stall) begin
            if (branch_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered = branch_queue.pop_front();
               req_valid <= 1'b1;
               req_action <= offered.action;
               req_pc <= offered.pc;
               req_predicted_taken <= offered.p_taken;
               req_predicted_target <= offered.p_target;
               req_actual_taken <= offered.a_taken;
               req_actual_target <= offered.a_target;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         failures++;
      end
   endfunction

   // result monitor and receiver stall
   always @(posedge clock) begin
      lookup_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_lookups.size() == 0) begin
               $display("%0t: unexpected item, actual outcome %0d target %h",
                        $time, rsp_outcome, rsp_pred_target);
               failures++;
            end else begin
               want = expected_lookups.pop_front();
               check_field("pred_taken", 32'(want.taken), 32'(rsp_pred_taken));
               check_field("btb_hit", 32'(want.hit), 32'(rsp_btb_hit));
               check_field("pred_target", want.target, rsp_pred_target);
               check_field("outcome", 32'(want.outcome), 32'(rsp_outcome));
            end
         end
         // one long hold-off so the pipeline backs up into req_stall
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_seen >= LONG_HOLD_AT) begin
            hold_done = 1;
            hold_left = LONG_HOLD_LEN;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   // watchdog: no item moving on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
